// File: rtl/brbc_pkg.sv
`timescale 1ns / 1ps

package brbc_pkg;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned OFF_W      = 5;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned WORD_IDX_W = 6;
  localparam int unsigned ROW_IDX_W  = 10;
  localparam int unsigned POS_W      = 6;   // bit position within a word, 0..32

  localparam logic [DIM_W-1:0] MAX_ROW_PIXELS = 11'd1024;
  localparam logic [DIM_W-1:0] MAX_ROWS       = 11'd1024;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_SRC_OFF = 2'd0,
    CFG_DST_OFF = 2'd1,
    CFG_WIDTH   = 2'd2,
    CFG_HEIGHT  = 2'd3
  } brbc_cfg_e;

  typedef struct packed {
    logic [OFF_W-1:0] src_off;
    logic [OFF_W-1:0] dst_off;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } brbc_cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0]     src_lo;
    logic [DATA_W-1:0]     src_hi;
    logic [DATA_W-1:0]     dst_old;
    logic [WORD_IDX_W-1:0] word_idx;
  } brbc_item_t;

  // First bit past the row span, counted from the first word of the row.
  function automatic logic [DIM_W-1:0] row_end_bit(logic [OFF_W-1:0] dst_off,
                                                   logic [DIM_W-1:0] width);
    logic [DIM_W-1:0] width_c;
    width_c = (width > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : width;
    return DIM_W'(dst_off) + width_c;
  endfunction

endpackage

// File: rtl/brbc_merge.sv
`timescale 1ns / 1ps

module brbc_merge import brbc_pkg::*; (
  input  brbc_item_t        item_i,
  input  brbc_cfg_t         cfg_i,
  output logic [DATA_W-1:0] word_o
);

  logic [OFF_W-1:0]    shift;
  logic [2*DATA_W-1:0] pair_shifted;
  logic [DATA_W-1:0]   src_aligned;
  logic [DIM_W-1:0]    lo_bit;
  logic [DIM_W-1:0]    hi_bit;
  logic [DIM_W-1:0]    base;
  logic [DIM_W-1:0]    start_diff;
  logic [DIM_W-1:0]    end_diff;
  logic [POS_W-1:0]    start_pos;
  logic [POS_W-1:0]    end_pos;
  logic [DATA_W-1:0]   mask;

  // Funnel shift of the source pair by the offset difference, mod 32
  assign shift        = cfg_i.src_off - cfg_i.dst_off;
  assign pair_shifted = {item_i.src_hi, item_i.src_lo} >> shift;
  assign src_aligned  = pair_shifted[DATA_W-1:0];

  assign lo_bit = DIM_W'(cfg_i.dst_off);
  assign hi_bit = row_end_bit(cfg_i.dst_off, cfg_i.width);
  assign base   = {item_i.word_idx, 5'b0};

  // Span relative to this word, clamped to [0, 32]
  assign start_diff = (lo_bit > base) ? (lo_bit - base) : '0;
  assign end_diff   = (hi_bit > base) ? (hi_bit - base) : '0;
  assign start_pos  = (start_diff > DIM_W'(DATA_W)) ? POS_W'(DATA_W) : start_diff[POS_W-1:0];
  assign end_pos    = (end_diff > DIM_W'(DATA_W)) ? POS_W'(DATA_W) : end_diff[POS_W-1:0];

  always_comb begin
    for (int j = 0; j < DATA_W; j++) begin
      mask[j] = (POS_W'(j) >= start_pos) && (POS_W'(j) < end_pos);
    end
  end

  assign word_o = (item_i.dst_old & ~mask) | (src_aligned & mask);

endmodule

// File: rtl/bit_row_block_copy.sv
`timescale 1ns / 1ps

// One-bit-per-pixel block copy engine. Every input transfer carries one
// destination word of the block (tdata: src_word_lo, src_word_hi, dst_word_old)
// and yields exactly one output transfer with the merged word, tlast on the
// last word of a row and tuser on the last word of the block. Bit 0 of a word
// is the leftmost pixel. The source pair is funnel-shifted by
// (src_bit_offset - dst_bit_offset) mod 32 and merged into the old word under
// the row-span mask. A row holds ceil((dst_bit_offset + width) / 32) words,
// at least one. Width is clamped to 1024, height to 1..1024. The feeder supplies
// the words in row order and handles addressing and overlap. Throughput is one
// word per clock while the output is not held back. Each word passes an input
// register, then the shift/mask/merge into the output register. Both stages
// hold under backpressure, so the input keeps accepting while the output
// waits as long as a stage is free. Write configuration only while idle;
// writes take effect at once and leave the word and row counters alone.
module bit_row_block_copy import brbc_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [1:0]            cfg_index_i,
  input  logic [DIM_W-1:0]      cfg_data_i,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [3*DATA_W-1:0]   s_axis_tdata_i,  // [31:0] src_word_lo, [63:32] src_word_hi,
                                                 // [95:64] dst_word_old
  // output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [DATA_W-1:0]     m_axis_tdata_o,  // [31:0] dst_word_new
  output logic                  m_axis_tlast_o,  // row_last
  output logic                  m_axis_tuser_o   // [0] block_last
);

  brbc_cfg_t cfg_q;

  logic [WORD_IDX_W-1:0] word_in_row_q, word_in_row_d;
  logic [ROW_IDX_W-1:0]  row_count_q, row_count_d;

  // input register stage
  logic       in_valid_q;
  brbc_item_t in_item_q;
  logic       in_rlast_q;
  logic       in_blast_q;

  // output register stage
  logic              out_valid_q;
  logic [DATA_W-1:0] out_data_q;
  logic              out_rlast_q;
  logic              out_blast_q;

  logic              s_fire;
  logic              out_advance;
  logic              in_advance;
  logic [DIM_W-1:0]  hi_bit;
  logic [DIM_W:0]    words_sum;
  logic [6:0]        words;
  logic [DIM_W-1:0]  height_c;
  logic              row_last;
  logic              block_last;
  logic [DATA_W-1:0] merged;

  // ---------------------------------------------------------------------------
  // Configuration registers; an index past the list is dropped
  // ---------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.src_off <= '0;
      cfg_q.dst_off <= '0;
      cfg_q.width   <= DIM_W'(1);
      cfg_q.height  <= DIM_W'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (brbc_cfg_e'(cfg_index_i))
        CFG_SRC_OFF: cfg_q.src_off <= cfg_data_i[OFF_W-1:0];
        CFG_DST_OFF: cfg_q.dst_off <= cfg_data_i[OFF_W-1:0];
        CFG_WIDTH:   cfg_q.width   <= cfg_data_i;
        CFG_HEIGHT:  cfg_q.height  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage advances when the stage after it is free or draining
  // ---------------------------------------------------------------------------
  assign out_advance     = !out_valid_q || m_axis_tready_i;
  assign in_advance      = !in_valid_q || out_advance;
  assign s_axis_tready_o = in_advance;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;

  // ---------------------------------------------------------------------------
  // Row and block end, decided from the counters at the input transfer
  // ---------------------------------------------------------------------------
  assign hi_bit    = row_end_bit(cfg_q.dst_off, cfg_q.width);
  assign words_sum = (DIM_W+1)'(hi_bit) + (DIM_W+1)'(DATA_W - 1);
  // zero-width row at offset zero still takes one word
  assign words     = (words_sum[DIM_W:5] == '0) ? 7'd1 : words_sum[DIM_W:5];
  assign height_c  = (cfg_q.height == '0)      ? DIM_W'(1) :
                     (cfg_q.height > MAX_ROWS) ? MAX_ROWS  : cfg_q.height;

  // a counter past its end (registers changed mid-block) counts as the end
  assign row_last   = ({1'b0, word_in_row_q} + 7'd1) >= words;
  assign block_last = row_last && (({1'b0, row_count_q} + DIM_W'(1)) >= height_c);

  always_comb begin
    word_in_row_d = word_in_row_q;
    row_count_d   = row_count_q;
    if (s_fire) begin
      if (block_last) begin
        word_in_row_d = '0;
        row_count_d   = '0;
      end else if (row_last) begin
        word_in_row_d = '0;
        row_count_d   = row_count_q + ROW_IDX_W'(1);
      end else begin
        word_in_row_d = word_in_row_q + WORD_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_in_row_q <= '0;
      row_count_q   <= '0;
    end else begin
      word_in_row_q <= word_in_row_d;
      row_count_q   <= row_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: hold the words and the word index for the merge stage
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_advance) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_item_q.src_lo   <= s_axis_tdata_i[DATA_W-1:0];
      in_item_q.src_hi   <= s_axis_tdata_i[2*DATA_W-1:DATA_W];
      in_item_q.dst_old  <= s_axis_tdata_i[3*DATA_W-1:2*DATA_W];
      in_item_q.word_idx <= word_in_row_q;
      in_rlast_q         <= row_last;
      in_blast_q         <= block_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Shift, mask and merge, then the output register
  // ---------------------------------------------------------------------------
  brbc_merge u_merge (
    .item_i (in_item_q),
    .cfg_i  (cfg_q),
    .word_o (merged)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_advance && in_valid_q) begin
      out_data_q  <= merged;
      out_rlast_q <= in_rlast_q;
      out_blast_q <= in_blast_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_rlast_q;
  assign m_axis_tuser_o  = out_blast_q;

endmodule

// File: tb/brbc_merge_checker.sv
`timescale 1ns / 1ps

// Watches the configuration, input and output channels of the block copy
// engine. Predicts each merged destination word as it enters and compares it
// with what leaves.
module brbc_merge_checker import brbc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [DIM_W-1:0]    cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [3*DATA_W-1:0] in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [DATA_W-1:0]   out_data_i,
  input  logic                out_last_i,
  input  logic                out_user_i,
  output int                  fail_count_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] word;
    logic              row_end;
    logic              block_end;
  } copy_result_t;

  brbc_cfg_t    cfg;
  int unsigned  word_idx;
  int unsigned  row_idx;
  copy_result_t merged_q[$];
  copy_result_t got_r;
  copy_result_t exp_r;
  int           mismatches = 0;
  int           results_seen = 0;

  // Shift the source pair, build the row-span mask for the current word and
  // merge under it; flag row and block end from the counters.
  function automatic copy_result_t merge_dst_word(logic [3*DATA_W-1:0] d);
    copy_result_t        r;
    logic [DIM_W-1:0]    w;
    logic [OFF_W-1:0]    sh;
    logic [2*DATA_W-1:0] pair;
    logic [DATA_W-1:0]   mask;
    int unsigned         h, lo_bit, hi_bit, base, a, b, words;
    w = (cfg.width > MAX_ROW_PIXELS) ? MAX_ROW_PIXELS : cfg.width;
    h = (cfg.height > MAX_ROWS) ? MAX_ROWS : cfg.height;
    if (h == 0) h = 1;
    sh = cfg.src_off - cfg.dst_off;
    pair = {d[2*DATA_W-1:DATA_W], d[DATA_W-1:0]} >> sh;
    lo_bit = cfg.dst_off;
    hi_bit = lo_bit + w;
    base = word_idx * DATA_W;
    a = (lo_bit > base) ? lo_bit - base : 0;
    b = (hi_bit > base) ? hi_bit - base : 0;
    if (a > DATA_W) a = DATA_W;
    if (b > DATA_W) b = DATA_W;
    for (int i = 0; i < DATA_W; i++) mask[i] = (i >= a) && (i < b);
    words = (hi_bit + DATA_W - 1) / DATA_W;
    if (words == 0) words = 1;
    r.row_end = (word_idx + 1 >= words);
    r.block_end = r.row_end && (row_idx + 1 >= h);
    r.word = (d[3*DATA_W-1:2*DATA_W] & ~mask) | (pair[DATA_W-1:0] & mask);
    return r;
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      cfg.src_off = '0;
      cfg.dst_off = '0;
      cfg.width   = DIM_W'(1);
      cfg.height  = DIM_W'(1);
      word_idx    = 0;
      row_idx     = 0;
      merged_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (brbc_cfg_e'(cfg_index_i))
          CFG_SRC_OFF: cfg.src_off = cfg_data_i[OFF_W-1:0];
          CFG_DST_OFF: cfg.dst_off = cfg_data_i[OFF_W-1:0];
          CFG_WIDTH:   cfg.width   = cfg_data_i;
          CFG_HEIGHT:  cfg.height  = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got_r.word      = out_data_i;
        got_r.row_end   = out_last_i;
        got_r.block_end = out_user_i;
        results_seen++;
        if (merged_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d arrived with nothing outstanding: word %h tlast %b tuser %b",
                     results_seen, got_r.word, got_r.row_end, got_r.block_end);
        end else begin
          exp_r = merged_q.pop_front();
          if (got_r.word !== exp_r.word || got_r.row_end !== exp_r.row_end ||
              got_r.block_end !== exp_r.block_end) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d differs: word exp %h got %h, row_last exp %b got %b, %s %b got %b",
                       results_seen, exp_r.word, got_r.word, exp_r.row_end, got_r.row_end,
                       "block_last exp", exp_r.block_end, got_r.block_end);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        exp_r = merge_dst_word(in_data_i);
        merged_q.push_back(exp_r);
        if (exp_r.block_end) begin
          word_idx = 0;
          row_idx  = 0;
        end else if (exp_r.row_end) begin
          word_idx = 0;
          row_idx++;
        end else begin
          word_idx++;
        end
      end
    end
    pending_o    = merged_q.size();
    fail_count_o = mismatches;
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the block copy engine. The checker beside the
// block predicts and compares; this module only drives the channels, shapes
// the idle patterns and decides pass or fail at the end.
module tb;
  import brbc_pkg::*;

  // Cycles with no transfer on any channel before the run is declared hung.
  // The longest legal quiet stretch is the long receiver hold-off.
  localparam int STALL_LIMIT = 4000;
  localparam int WORD_GOAL   = 1000;
  localparam int CALM_FROM   = 850;   // no idling in phases that start once this many words went in

  logic                clk;
  logic                rst_n;
  logic                cfg_valid;
  logic                cfg_ready;
  brbc_cfg_e           cfg_index;
  logic [DIM_W-1:0]    cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [3*DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [DATA_W-1:0]   m_tdata;
  logic                m_tlast;
  logic                m_tuser;

  int fails;
  int pending;
  int words_sent   = 0;
  int quiet_cycles = 0;
  bit tx_idle_en   = 1'b0;
  bit rx_idle_en   = 1'b0;
  int rx_hold      = 0;   // long receiver hold-off, counted down by the receiver
  int rx_gap       = 0;

  bit_row_block_copy dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tuser_o  (m_tuser)
  );

  brbc_merge_checker chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (s_tvalid),
    .in_ready_i   (s_tready),
    .in_data_i    (s_tdata),
    .out_valid_i  (m_tvalid),
    .out_ready_i  (m_tready),
    .out_data_i   (m_tdata),
    .out_last_i   (m_tlast),
    .out_user_i   (m_tuser),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: honor a requested hold-off first, then random stall bursts
  // while idling is enabled, otherwise stay ready.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_tready = 1'b0;
        rx_gap--;
      end else if (rx_idle_en && $urandom_range(0, 6) == 0) begin
        m_tready = 1'b0;
        rx_gap = $urandom_range(1, 14) - 1;
      end else begin
        m_tready = 1'b1;
      end
    end
  end

  // Watchdog: count cycles in which no channel moves a transfer.
  always @(posedge clk) begin
    if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("bit_row_block_copy: mismatch");
      $finish;
    end
  end

  // Mostly random words, with all-zero and all-one words mixed in.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Offer one destination word; valid stays high afterwards so that back-to-back
  // words need no toggle. Drop it with idle_inputs before waiting on anything.
  task automatic send_word(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                           input logic [DATA_W-1:0] old);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {old, hi, lo};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic write_reg(input brbc_cfg_e idx, input logic [DIM_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic idle_inputs();
    s_tvalid  = 1'b0;
    cfg_valid = 1'b0;
  endtask

  // Hold the input until every predicted word has come out.
  task automatic drain();
    idle_inputs();
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [DIM_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return DIM_W'(0);
      1:       return DIM_W'(31);
      default: return DIM_W'($urandom_range(0, 2047));   // upper bits must be ignored
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_width();
    case ($urandom_range(0, 19))
      0:       return DIM_W'(0);
      1:       return DIM_W'(1024);
      2:       return DIM_W'($urandom_range(1025, 2047));
      3:       return DIM_W'($urandom_range(200, 1023));
      default: return DIM_W'($urandom_range(1, 96));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_height();
    case ($urandom_range(0, 19))
      0:       return DIM_W'(0);
      1:       return DIM_W'(1024);
      2:       return DIM_W'($urandom_range(1025, 2047));
      default: return DIM_W'($urandom_range(1, 6));
    endcase
  endfunction

  initial begin
    int  phase;
    int  n;
    bit  wrote;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SRC_OFF;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Reset settings: one-pixel rows, every word ends the block.
    send_word('1, '0, '0);
    send_word('0, '1, '1);

    // Widest source offset, width clamped from above, zero height.
    drain();
    write_reg(CFG_SRC_OFF, DIM_W'(31));
    write_reg(CFG_DST_OFF, DIM_W'(0));
    write_reg(CFG_WIDTH, DIM_W'(2047));
    write_reg(CFG_HEIGHT, DIM_W'(0));
    idle_inputs();
    send_word(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_F0F0);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, '1);
    send_word('1, '0, '0);

    // Shrink the row mid-block: the word index is past the new row end.
    drain();
    write_reg(CFG_WIDTH, DIM_W'(40));
    idle_inputs();
    send_word('1, '1, '0);

    // Zero width at the last destination offset: old word passes through.
    drain();
    write_reg(CFG_SRC_OFF, DIM_W'(0));
    write_reg(CFG_DST_OFF, DIM_W'(31));
    write_reg(CFG_WIDTH, DIM_W'(0));
    idle_inputs();
    send_word('1, '1, 32'h1234_5678);
    send_word('0, '0, 32'hFEDC_BA98);

    // Two-pixel rows straddling a word edge, height clamped from above.
    drain();
    write_reg(CFG_SRC_OFF, DIM_W'(5));
    write_reg(CFG_WIDTH, DIM_W'(2));
    write_reg(CFG_HEIGHT, DIM_W'(2047));
    idle_inputs();
    repeat (4) send_word(pick_word(), pick_word(), pick_word());

    // Lower the height below the current row: the next row end closes the block.
    drain();
    write_reg(CFG_HEIGHT, DIM_W'(1));
    idle_inputs();
    repeat (2) send_word(pick_word(), pick_word(), pick_word());

    // Random phases: new settings while idle, then a run of words.
    phase = 0;
    while (words_sent < WORD_GOAL) begin
      drain();
      tx_idle_en = (words_sent < CALM_FROM) && ($urandom_range(0, 2) != 0);
      rx_idle_en = (words_sent < CALM_FROM) && ($urandom_range(0, 2) != 0);
      wrote = 1'b0;
      if ($urandom_range(0, 1)) begin write_reg(CFG_SRC_OFF, pick_offset()); wrote = 1'b1; end
      if ($urandom_range(0, 1)) begin write_reg(CFG_DST_OFF, pick_offset()); wrote = 1'b1; end
      if ($urandom_range(0, 1)) begin write_reg(CFG_HEIGHT, pick_height()); wrote = 1'b1; end
      if (!wrote || $urandom_range(0, 1)) write_reg(CFG_WIDTH, pick_width());
      idle_inputs();
      // Stall the output for a long stretch so the block backs up into its input.
      if (phase == 4) rx_hold = 300;
      n = (phase == 4) ? 80 : $urandom_range(1, 80);
      for (int k = 0; k < n; k++) begin
        // Pause the sender once until everything in flight has come out.
        if (phase == 7 && k == n / 2) drain();
        send_word(pick_word(), pick_word(), pick_word());
      end
      phase++;
    end

    drain();
    repeat (10) @(negedge clk);
    if (fails == 0 && pending == 0) begin
      $display("bit_row_block_copy: match");
    end else begin
      $display("bit_row_block_copy: mismatch");
    end
    $finish;
  end

endmodule
